[rtl/core/speed_pi_controller_distance_scaled_macros.svh]
// Assertion macros for the distance-scaled speed PI controller
`ifndef SPEED_PI_CONTROLLER_DISTANCE_SCALED_MACROS_SVH
`define SPEED_PI_CONTROLLER_DISTANCE_SCALED_MACROS_SVH

// same-cycle implication
`define SPCDS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("spcds: check failed");

// next-cycle implication
`define SPCDS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("spcds: check failed");

`endif

[rtl/core/spcds_pkg.sv]
// Shared types and constants of the distance-scaled speed PI controller
`default_nettype none

package spcds_pkg;

  localparam int MC_W      = 34;
  localparam int MP_W      = 31;
  localparam int H_W       = MC_W + 1;
  localparam int PROD_W    = H_W + MP_W;
  localparam int MUL_STEPS = MP_W;
  localparam int CNT_W     = $clog2(MUL_STEPS);

  localparam logic [17:0] SAFE_REQUEST  = 18'd9830;
  localparam logic [17:0] MIN_SETPOINT  = 18'd3277;
  localparam logic [31:0] REQ_CUTOFF    = 32'd131727;
  localparam logic [17:0] OVERSHOOT_DEC = 18'd13107;
  localparam logic [17:0] Q_ONE         = 18'd65536;

  localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN    = 3'd1;
  localparam logic [2:0] REG_TIME_STEP     = 3'd2;
  localparam logic [2:0] REG_INTEG_CEILING = 3'd3;
  localparam logic [2:0] REG_INTEG_START   = 3'd4;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

`default_nettype wire

[rtl/core/spcds_ser_mul.sv]
// Bit-serial signed by unsigned shift-add multiplier
`default_nettype none

module spcds_ser_mul (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic signed [spcds_pkg::MC_W-1:0]   mcand,
  input  wire logic        [spcds_pkg::MP_W-1:0]   mplier,
  output logic signed      [spcds_pkg::PROD_W-1:0] product,
  output spcds_pkg::mul_stat_t                     stat
);

  logic signed [spcds_pkg::H_W-1:0]   h_r, h_nxt;
  logic        [spcds_pkg::MP_W-1:0]  l_r, l_nxt;
  logic        [spcds_pkg::MP_W-1:0]  m_r;
  logic signed [spcds_pkg::MC_W-1:0]  mc_r;
  logic        [spcds_pkg::CNT_W-1:0] cnt_r;
  logic                               run_r;
  logic                               done_r;
  logic signed [spcds_pkg::H_W-1:0]   addend;
  logic signed [spcds_pkg::H_W-1:0]   sum;

  always_comb begin
    addend = m_r[0] ? {mc_r[spcds_pkg::MC_W-1], mc_r} : '0;
    sum    = h_r + addend;
    h_nxt  = {sum[spcds_pkg::H_W-1], sum[spcds_pkg::H_W-1:1]};
    l_nxt  = {sum[0], l_r[spcds_pkg::MP_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == spcds_pkg::CNT_W'(spcds_pkg::MUL_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      h_r  <= '0;
      l_r  <= '0;
      m_r  <= mplier;
      mc_r <= mcand;
    end else if (run_r) begin
      h_r <= h_nxt;
      l_r <= l_nxt;
      m_r <= m_r >> 1;
    end
  end

  assign product   = {h_r, l_r};
  assign stat.busy = run_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

[rtl/core/speed_pi_controller_distance_scaled.sv]
// Top level of the distance-scaled speed PI controller
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  target_distance, speed_request, measured_speed
//   out      output     out_valid/out_stall  drive_command, prop_term, integ_term, target_ahead
//   cfg      input      APB psel/penable     paddr[4:2] selects register, pwdata 32 bits
//
// The shared bit-serial multiplier, one multiplier bit per cycle over 31 steps, sets how long
// one word takes from acceptance to result.
// A new input word is taken once the previous one has left the sequencer.
// A finished result waits in the output register while out_stall is high.
// Reset is synchronous, active low; the integral loads integ_start.
`default_nettype none

`include "speed_pi_controller_distance_scaled_macros.svh"

module speed_pi_controller_distance_scaled (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_target_distance,
  input  wire logic signed [31:0] in_speed_request,
  input  wire logic signed [31:0] in_measured_speed,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [17:0]      out_drive_command,
  output logic signed [31:0]      out_prop_term,
  output logic signed [31:0]      out_integ_term,
  output logic                    out_target_ahead,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETP  = 3'd1;
  localparam logic [2:0] ST_PROP  = 3'd2;
  localparam logic [2:0] ST_INTEG = 3'd3;
  localparam logic [2:0] ST_ACC   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = 50'sh7FFFFFFF;
    lo = -50'sh80000000;
    if (x > hi) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (x < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

  logic [30:0]        prop_gain_r;
  logic [30:0]        integ_gain_r;
  logic [16:0]        time_step_r;
  logic signed [31:0] integ_ceiling_r;
  logic signed [31:0] integ_start_r;
  logic signed [31:0] accum_r, accum_nxt;

  logic [2:0]         state_r, state_nxt;
  logic               launched_r;
  logic [31:0]        dist_r;
  logic [17:0]        req_r;
  logic signed [31:0] meas_r;
  logic               overshoot_r;
  logic signed [32:0] err_r, err_nxt;
  logic signed [31:0] pterm_r;
  logic signed [31:0] iterm_r;

  logic               out_valid_r;
  logic signed [17:0] out_drive_command_r;
  logic signed [31:0] out_prop_term_r;
  logic signed [31:0] out_integ_term_r;
  logic               out_target_ahead_r;

  logic                                    cfg_wr;
  logic [2:0]                              reg_idx;
  logic                                    in_acc;
  logic                                    mul_start;
  logic signed [spcds_pkg::MC_W-1:0]       mul_mcand;
  logic        [spcds_pkg::MP_W-1:0]       mul_mplier;
  logic signed [spcds_pkg::PROD_W-1:0]     mul_prod;
  spcds_pkg::mul_stat_t                    mul_stat;
  logic signed [49:0]                      prod_sh16;
  logic [31:0]                             setp_q;
  logic [17:0]                             setp_lim;
  logic signed [35:0]                      acc_sum;
  logic signed [35:0]                      ceil_ext;
  logic signed [33:0]                      cmd_sum;
  logic signed [17:0]                      cmd_sat;
  logic                                    out_load;
  logic                                    in_mul_state;

  assign cfg_wr   = psel && penable && pwrite && pready;
  assign reg_idx  = paddr[4:2];
  assign pready   = 1'b1;
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    unique case (reg_idx)
      spcds_pkg::REG_PROP_GAIN:     prdata = {1'b0, prop_gain_r};
      spcds_pkg::REG_INTEG_GAIN:    prdata = {1'b0, integ_gain_r};
      spcds_pkg::REG_TIME_STEP:     prdata = {15'b0, time_step_r};
      spcds_pkg::REG_INTEG_CEILING: prdata = integ_ceiling_r;
      spcds_pkg::REG_INTEG_START:   prdata = integ_start_r;
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r     <= 31'd65536;
      integ_gain_r    <= 31'd65536;
      time_step_r     <= 17'd1311;
      integ_ceiling_r <= 32'sd32768;
      integ_start_r   <= -32'sd26214;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        spcds_pkg::REG_PROP_GAIN:     prop_gain_r     <= pwdata[30:0];
        spcds_pkg::REG_INTEG_GAIN:    integ_gain_r    <= pwdata[30:0];
        spcds_pkg::REG_TIME_STEP:     time_step_r     <= pwdata[16:0];
        spcds_pkg::REG_INTEG_CEILING: integ_ceiling_r <= pwdata;
        spcds_pkg::REG_INTEG_START:   integ_start_r   <= pwdata;
        default: ;
      endcase
    end
  end

  assign in_mul_state = (state_r == ST_SETP) || (state_r == ST_PROP) ||
                        (state_r == ST_INTEG) || (state_r == ST_ACC);
  assign mul_start    = in_mul_state && !launched_r;

  always_comb begin
    unique case (state_r)
      ST_SETP: begin
        mul_mcand  = {2'b00, dist_r};
        mul_mplier = {13'b0, req_r};
      end
      ST_PROP: begin
        mul_mcand  = {err_r[32], err_r};
        mul_mplier = prop_gain_r;
      end
      ST_INTEG: begin
        mul_mcand  = {{2{accum_r[31]}}, accum_r};
        mul_mplier = integ_gain_r;
      end
      ST_ACC: begin
        mul_mcand  = {err_r[32], err_r};
        mul_mplier = {14'b0, time_step_r};
      end
      default: begin
        mul_mcand  = '0;
        mul_mplier = '0;
      end
    endcase
  end

  spcds_ser_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mul_mcand),
    .mplier  (mul_mplier),
    .product (mul_prod),
    .stat    (mul_stat)
  );

  assign prod_sh16 = mul_prod[spcds_pkg::PROD_W-1:16];
  assign setp_q    = mul_prod[spcds_pkg::PROD_W-18:17];

  always_comb begin
    if (setp_q >= {14'b0, req_r}) begin
      setp_lim = req_r;
    end else begin
      setp_lim = setp_q[17:0];
    end
    if (setp_lim <= spcds_pkg::MIN_SETPOINT) begin
      setp_lim = spcds_pkg::MIN_SETPOINT;
    end
    err_nxt = $signed({15'b0, setp_lim}) - $signed({meas_r[31], meas_r});
  end

  always_comb begin
    ceil_ext  = {{4{integ_ceiling_r[31]}}, integ_ceiling_r};
    acc_sum   = {{4{accum_r[31]}}, accum_r} + prod_sh16[35:0];
    if (acc_sum >= ceil_ext) begin
      accum_nxt = integ_ceiling_r;
    end else if (acc_sum < -36'sh80000000) begin
      accum_nxt = 32'sh80000000;
    end else begin
      accum_nxt = acc_sum[31:0];
    end
  end

  always_comb begin
    cmd_sum = {{2{pterm_r[31]}}, pterm_r} + {{2{iterm_r[31]}}, iterm_r};
    if (overshoot_r) begin
      cmd_sum = cmd_sum - $signed({16'b0, spcds_pkg::OVERSHOOT_DEC});
    end
    if (cmd_sum > $signed({16'b0, spcds_pkg::Q_ONE})) begin
      cmd_sat = $signed(spcds_pkg::Q_ONE);
    end else if (cmd_sum < -$signed({16'b0, spcds_pkg::Q_ONE})) begin
      cmd_sat = -$signed(spcds_pkg::Q_ONE);
    end else begin
      cmd_sat = cmd_sum[17:0];
    end
  end

  assign out_load = (state_r == ST_DONE) && !(out_valid_r && out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_SETP;
      ST_SETP:  if (mul_stat.done) state_nxt = ST_PROP;
      ST_PROP:  if (mul_stat.done) state_nxt = ST_INTEG;
      ST_INTEG: if (mul_stat.done) state_nxt = ST_ACC;
      ST_ACC:   if (mul_stat.done) state_nxt = ST_DONE;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
      accum_r     <= -32'sd26214;
    end else begin
      state_r <= state_nxt;
      if (mul_stat.done) begin
        launched_r <= 1'b0;
      end else if (mul_start) begin
        launched_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr && (reg_idx == spcds_pkg::REG_INTEG_START)) begin
        accum_r <= pwdata;
      end else if ((state_r == ST_ACC) && mul_stat.done) begin
        accum_r <= accum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      overshoot_r <= in_target_distance[31];
      dist_r      <= in_target_distance[31] ? 32'd0 : in_target_distance;
      meas_r      <= in_measured_speed;
      if (in_speed_request[31] || (in_speed_request > $signed(spcds_pkg::REQ_CUTOFF))) begin
        req_r <= spcds_pkg::SAFE_REQUEST;
      end else begin
        req_r <= in_speed_request[17:0];
      end
    end
    if ((state_r == ST_SETP) && mul_stat.done) begin
      err_r <= err_nxt;
    end
    if ((state_r == ST_PROP) && mul_stat.done) begin
      pterm_r <= sat32(prod_sh16);
    end
    if ((state_r == ST_INTEG) && mul_stat.done) begin
      iterm_r <= sat32(prod_sh16);
    end
    if (out_load) begin
      out_drive_command_r <= cmd_sat;
      out_prop_term_r     <= pterm_r;
      out_integ_term_r    <= iterm_r;
      out_target_ahead_r  <= !overshoot_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drive_command = out_drive_command_r;
  assign out_prop_term     = out_prop_term_r;
  assign out_integ_term    = out_integ_term_r;
  assign out_target_ahead  = out_target_ahead_r;

  `SPCDS_ASSERT_NXT(a_accept_starts, clk, rst_n, rst_n && in_acc, state_r == ST_SETP)
  `SPCDS_ASSERT_IMP(a_cmd_range, clk, rst_n, out_valid_r, (out_drive_command_r <= 18'sd65536) && (out_drive_command_r >= -18'sd65536))
  `SPCDS_ASSERT_IMP(a_start_free, clk, rst_n, mul_start, !mul_stat.busy)
  `SPCDS_ASSERT_IMP(a_done_launched, clk, rst_n, mul_stat.done, launched_r && in_mul_state)
  `SPCDS_ASSERT_NXT(a_accum_ceiling, clk, rst_n, rst_n && (state_r == ST_ACC) && mul_stat.done && !cfg_wr, accum_r <= integ_ceiling_r)

endmodule

`default_nettype wire

[bench/speed_pi_controller_distance_scaled_tb.sv]
// Self-checking bench for the distance-scaled speed PI controller: predicted vs. DUT results
`default_nettype none

module speed_pi_controller_distance_scaled_tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_WORDS   = 1700;
  localparam int PHASE_WORDS    = 170;

  localparam logic [2:0] REG_SPARE_5 = 3'd5;
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  localparam logic [31:0] DEF_PROP_GAIN     = 32'd65536;
  localparam logic [31:0] DEF_INTEG_GAIN    = 32'd65536;
  localparam logic [31:0] DEF_TIME_STEP     = 32'd1311;
  localparam logic [31:0] DEF_INTEG_CEILING = 32'd32768;
  localparam logic [31:0] DEF_INTEG_START   = 32'hFFFF_999A;

  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;
  localparam int          ONE     = 65536;

  typedef struct packed {
    logic signed [17:0] drive_command;
    logic signed [31:0] prop_term;
    logic signed [31:0] integ_term;
    logic               target_ahead;
  } drive_word_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic signed [31:0]  in_target_distance = '0;
  logic signed [31:0]  in_speed_request = '0;
  logic signed [31:0]  in_measured_speed = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic signed [17:0]  out_drive_command;
  logic signed [31:0]  out_prop_term;
  logic signed [31:0]  out_integ_term;
  logic                out_target_ahead;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [4:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // controller shadow state
  logic [30:0]         gain_p;
  logic [30:0]         gain_i;
  logic [16:0]         step_dt;
  logic signed [31:0]  integ_cap;
  logic signed [31:0]  integ_init;
  logic signed [31:0]  integ_acc;

  drive_word_t         drive_q[$];
  int                  errors = 0;
  int                  quiet_cycles = 0;
  int                  stall_left = 0;
  int                  stall_pick;
  bit                  tx_idle_en = 1'b1;
  bit                  rx_idle_en = 1'b1;

  speed_pi_controller_distance_scaled u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_target_distance (in_target_distance),
    .in_speed_request   (in_speed_request),
    .in_measured_speed  (in_measured_speed),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_drive_command  (out_drive_command),
    .out_prop_term      (out_prop_term),
    .out_integ_term     (out_integ_term),
    .out_target_ahead   (out_target_ahead),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint clamp32(input longint x);
    if (x > longint'(signed'(S32_MAX))) return longint'(signed'(S32_MAX));
    if (x < longint'(signed'(S32_MIN))) return longint'(signed'(S32_MIN));
    return x;
  endfunction

  // predict one result and advance the integral
  function automatic drive_word_t predict_drive(input logic signed [31:0] dist_in,
                                                input logic signed [31:0] req_in,
                                                input logic signed [31:0] meas_in);
    longint      dist_v, req, meas, setp, err, pterm, iterm, cmd, acc;
    logic        overshoot;
    drive_word_t r;
    dist_v = dist_in;
    req = req_in;
    meas = meas_in;
    overshoot = 1'b0;
    if (dist_v < 0) begin
      dist_v = 0;
      overshoot = 1'b1;
    end
    if (req < 0 || req > longint'(spcds_pkg::REQ_CUTOFF))
      req = longint'(spcds_pkg::SAFE_REQUEST);
    setp = (dist_v * req) >>> 17;
    if (setp >= req) setp = req;
    if (setp <= longint'(spcds_pkg::MIN_SETPOINT)) setp = longint'(spcds_pkg::MIN_SETPOINT);
    err = setp - meas;
    pterm = clamp32((longint'({33'd0, gain_p}) * err) >>> 16);
    iterm = clamp32((longint'({33'd0, gain_i}) * longint'(integ_acc)) >>> 16);
    cmd = pterm + iterm;
    if (overshoot) cmd = cmd - longint'(spcds_pkg::OVERSHOOT_DEC);
    if (cmd > longint'(spcds_pkg::Q_ONE)) cmd = longint'(spcds_pkg::Q_ONE);
    if (cmd < -longint'(spcds_pkg::Q_ONE)) cmd = -longint'(spcds_pkg::Q_ONE);
    acc = longint'(integ_acc) + ((err * longint'({47'd0, step_dt})) >>> 16);
    if (acc >= longint'(integ_cap)) acc = longint'(integ_cap);
    integ_acc = 32'(clamp32(acc));
    r.drive_command = cmd[17:0];
    r.prop_term = pterm[31:0];
    r.integ_term = iterm[31:0];
    r.target_ahead = ~overshoot;
    return r;
  endfunction

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic int tx_gap();
    int r;
    if (!tx_idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic int rx_stall_len();
    int r;
    if (!rx_idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 96) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // hold stall for a run of cycles, then release
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_pick = rx_stall_len();
      out_stall <= (stall_pick > 0);
      stall_left <= (stall_pick > 0) ? stall_pick - 1 : 0;
    end
  end

  always @(posedge clk) begin
    drive_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (drive_q.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        e = drive_q.pop_front();
        if (out_drive_command !== e.drive_command)
          report($sformatf("drive_command got %0d expected %0d",
                           out_drive_command, e.drive_command));
        if (out_prop_term !== e.prop_term)
          report($sformatf("prop_term got %0d expected %0d", out_prop_term, e.prop_term));
        if (out_integ_term !== e.integ_term)
          report($sformatf("integ_term got %0d expected %0d", out_integ_term, e.integ_term));
        if (out_target_ahead !== e.target_ahead)
          report($sformatf("target_ahead got %0b expected %0b",
                           out_target_ahead, e.target_ahead));
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (psel && penable && pwrite && pready) || !rst_n)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d words outstanding", drive_q.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_word(input logic signed [31:0] dist_in, input logic signed [31:0] req,
                           input logic signed [31:0] meas);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_target_distance <= dist_in;
    in_speed_request <= req;
    in_measured_speed <= meas;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    drive_q.push_back(predict_drive(dist_in, req, meas));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      spcds_pkg::REG_PROP_GAIN:     gain_p = value[30:0];
      spcds_pkg::REG_INTEG_GAIN:    gain_i = value[30:0];
      spcds_pkg::REG_TIME_STEP:     step_dt = value[16:0];
      spcds_pkg::REG_INTEG_CEILING: integ_cap = value;
      spcds_pkg::REG_INTEG_START: begin
        integ_init = value;
        integ_acc = value;
      end
      default: ;
    endcase
  endtask

  task automatic restore_defaults();
    cfg_write(spcds_pkg::REG_PROP_GAIN, DEF_PROP_GAIN);
    cfg_write(spcds_pkg::REG_INTEG_GAIN, DEF_INTEG_GAIN);
    cfg_write(spcds_pkg::REG_TIME_STEP, DEF_TIME_STEP);
    cfg_write(spcds_pkg::REG_INTEG_CEILING, DEF_INTEG_CEILING);
    cfg_write(spcds_pkg::REG_INTEG_START, DEF_INTEG_START);
  endtask

  function automatic logic [31:0] pick_distance();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return -$urandom_range(1, 5 * ONE);
      2: return ($urandom_range(0, 1) != 0) ? S32_MIN : S32_MAX;
      default: return $urandom_range(0, 20 * ONE);
    endcase
  endfunction

  function automatic logic [31:0] pick_request();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(spcds_pkg::REQ_CUTOFF - 8, spcds_pkg::REQ_CUTOFF + 8);
      2: return -$urandom_range(1, 3 * ONE);
      default: return $urandom_range(0, spcds_pkg::REQ_CUTOFF);
    endcase
  endfunction

  function automatic logic [31:0] pick_speed();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return ($urandom_range(0, 1) != 0) ? S32_MIN : S32_MAX;
      default: return $urandom_range(0, 3 * ONE) - ONE / 2;
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return S32_MAX;
      2: return $urandom;
      default: return $urandom_range(0, 4 * ONE);
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return ONE;
      2: return 32'h0001_FFFF;
      default: return $urandom_range(1, ONE / 4);
    endcase
  endfunction

  function automatic logic [31:0] pick_integ();
    case ($urandom_range(0, 7))
      0: return S32_MIN;
      1: return S32_MAX;
      2: return $urandom;
      default: return $urandom_range(0, 2 * ONE) - ONE;
    endcase
  endfunction

  task automatic test_reset_state();
    repeat (6) send_word(pick_distance(), pick_request(), pick_speed());
    drain();
  endtask

  task automatic test_field_extremes();
    send_word(3 * ONE, ONE, 0);
    send_word(-1, ONE, 0);
    send_word(S32_MIN, ONE, ONE);
    send_word(S32_MAX, spcds_pkg::REQ_CUTOFF, 0);
    send_word(4 * ONE, spcds_pkg::REQ_CUTOFF + 32'd1, 0);
    send_word(4 * ONE, -1, 0);
    send_word(4 * ONE, S32_MIN, 0);
    send_word(4 * ONE, S32_MAX, 0);
    send_word(0, 0, 0);
    send_word(ONE, ONE, S32_MAX);
    send_word(ONE, ONE, S32_MIN);
    send_word(0, spcds_pkg::REQ_CUTOFF, -1);
    send_word(-ONE, 32'(spcds_pkg::SAFE_REQUEST), 32'(spcds_pkg::MIN_SETPOINT));
    send_word(6554, ONE, 32'(spcds_pkg::MIN_SETPOINT));
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'h5555_5555, 32'h0000_AAAA, 32'hAAAA_AAAA);
    send_word(32'hAAAA_AAAA, 32'h0001_5555, 32'h5555_5555);
    drain();
  endtask

  task automatic test_register_settings();
    cfg_write(spcds_pkg::REG_PROP_GAIN, S32_MAX);
    cfg_write(spcds_pkg::REG_INTEG_GAIN, S32_MAX);
    send_word(0, 0, S32_MIN);
    send_word(0, 0, S32_MAX);
    send_word(-ONE, ONE, 0);
    drain();
    cfg_write(spcds_pkg::REG_TIME_STEP, 32'h0001_FFFF);
    cfg_write(spcds_pkg::REG_INTEG_CEILING, S32_MAX);
    cfg_write(spcds_pkg::REG_INTEG_START, S32_MIN);
    send_word(ONE, ONE, S32_MAX);
    send_word(ONE, ONE, S32_MIN);
    send_word(ONE, ONE, S32_MIN);
    send_word(ONE, ONE, 0);
    drain();
    cfg_write(spcds_pkg::REG_INTEG_CEILING, S32_MIN);
    cfg_write(spcds_pkg::REG_INTEG_START, S32_MAX);
    send_word(ONE, ONE, 0);
    send_word(ONE, ONE, S32_MIN);
    drain();
    cfg_write(spcds_pkg::REG_PROP_GAIN, 32'd0);
    cfg_write(spcds_pkg::REG_INTEG_GAIN, 32'd0);
    cfg_write(spcds_pkg::REG_TIME_STEP, 32'd0);
    cfg_write(spcds_pkg::REG_INTEG_CEILING, 32'd0);
    cfg_write(spcds_pkg::REG_INTEG_START, 32'd0);
    send_word(-1, ONE, 0);
    send_word(5 * ONE, ONE, S32_MIN);
    drain();
    cfg_write(spcds_pkg::REG_PROP_GAIN, 32'hFFFF_FFFF);
    cfg_write(spcds_pkg::REG_INTEG_GAIN, 32'h8000_0001);
    cfg_write(spcds_pkg::REG_TIME_STEP, 32'hFFFF_FFFF);
    cfg_write(REG_SPARE_5, $urandom);
    cfg_write(REG_SPARE_6, $urandom);
    cfg_write(REG_SPARE_7, $urandom);
    send_word(2 * ONE, ONE, ONE / 2);
    send_word(2 * ONE, ONE, -ONE);
    drain();
    restore_defaults();
    send_word(2 * ONE, ONE, 0);
    drain();
  endtask

  task automatic test_random_traffic();
    int phase;
    phase = 0;
    for (int sent = 0; sent < RANDOM_WORDS; sent += PHASE_WORDS) begin
      if (phase % 4 == 1) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end else begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
      end
      if (phase % 3 == 0) begin
        restore_defaults();
      end else begin
        cfg_write(spcds_pkg::REG_PROP_GAIN, pick_gain());
        cfg_write(spcds_pkg::REG_INTEG_GAIN, pick_gain());
        cfg_write(spcds_pkg::REG_TIME_STEP, pick_step());
        cfg_write(spcds_pkg::REG_INTEG_CEILING, pick_integ());
        if ($urandom_range(0, 1) != 0) cfg_write(spcds_pkg::REG_INTEG_START, pick_integ());
      end
      repeat (PHASE_WORDS) send_word(pick_distance(), pick_request(), pick_speed());
      drain();
      phase++;
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    gain_p = DEF_PROP_GAIN[30:0];
    gain_i = DEF_INTEG_GAIN[30:0];
    step_dt = DEF_TIME_STEP[16:0];
    integ_cap = DEF_INTEG_CEILING;
    integ_init = DEF_INTEG_START;
    integ_acc = DEF_INTEG_START;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_field_extremes();
    test_register_settings();
    test_random_traffic();
    drain();
    if (drive_q.size() != 0) report($sformatf("%0d words never arrived", drive_q.size()));
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
+incdir+rtl/core
rtl/core/spcds_pkg.sv
rtl/core/spcds_ser_mul.sv
rtl/core/speed_pi_controller_distance_scaled.sv
bench/speed_pi_controller_distance_scaled_tb.sv
